// File: rtl/euler_to_direction_vector_assert.svh
// Assertion macros shared by the checker of the direction vector block
`ifndef EULER_TO_DIRECTION_VECTOR_ASSERT_SVH
`define EULER_TO_DIRECTION_VECTOR_ASSERT_SVH

// same-cycle implication, muted during reset
`define E2D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, muted during reset
`define E2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define E2D_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/e2d_pkg.sv
// Shared types, constants and fixed-point helpers of the direction vector block
package e2d_pkg;

  localparam longint QONE_L        = 64'sd1073741824;
  localparam longint HALF_PI       = 64'sd1686629713;
  localparam longint QTR_PI        = 64'sd843314856;
  localparam logic [30:0] QONE     = 31'h4000_0000;
  localparam int SERIES_TERMS      = 7;
  localparam int RANGE_STEPS       = 6;
  localparam int SC_STAGES         = 3 + 3 * SERIES_TERMS + 2;
  localparam int ROOT_STEPS        = 32;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } quad_t;

  typedef struct packed {
    logic       nz;
    logic [2:0] neg;
  } comp_flags_t;

  // Q30 product, floored
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p[61:30];
  endfunction

endpackage

// File: rtl/e2d_flow.sv
// Valid tracking for the pipeline and the two-entry result buffer
module e2d_flow #(
  parameter int STAGES = 2,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              en,
  input  logic [DATA_W-1:0] last_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic [STAGES-1:0] vld_r;
  logic [DATA_W-1:0] buf_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              push, pop;

  // pipeline moves while the buffer has a free slot
  assign en        = (cnt_r != 2'd2);
  assign in_ready  = en;
  assign push      = en & vld_r[STAGES-1];
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid & out_ready;
  assign out_data  = buf_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[STAGES-2:0], in_valid};
      end
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= last_data;
    end
  end

endmodule

// File: rtl/e2d_trig_cell.sv
// One Horner step of the sine and cosine series, three register stages
module e2d_trig_cell import e2d_pkg::*; #(
  parameter int K      = 1,
  parameter int SIDE_W = 34
) (
  input  logic              clk,
  input  logic              en,
  input  logic [29:0]       r2_i,
  input  logic [30:0]       ts_i,
  input  logic [30:0]       tc_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [29:0]       r2_o,
  output logic [30:0]       ts_o,
  output logic [30:0]       tc_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int DS = (2 * K) * (2 * K + 1);
  localparam int DC = (2 * K - 1) * (2 * K);
  localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
  localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);

  logic [29:0]       r2a_r, r2b_r, r2c_r;
  logic [SIDE_W-1:0] sda_r, sdb_r, sdc_r;
  logic [30:0]       psa_r, pca_r, psb_r, pcb_r, qsb_r, qcb_r;
  logic [30:0]       tsc_r, tcc_r;

  logic [60:0] ps_full, pc_full;
  logic [62:0] qs_full, qc_full;
  logic [39:0] rem_s, rem_c;
  logic [30:0] qfs, qfc;

  always_comb begin
    ps_full = 61'(r2_i) * 61'(ts_i);
    pc_full = 61'(r2_i) * 61'(tc_i);
    // reciprocal estimate is low by at most one
    qs_full = 63'(psa_r) * 63'(MS);
    qc_full = 63'(pca_r) * 63'(MC);
    rem_s   = 40'(psb_r) - 40'(qsb_r) * 40'(DS);
    rem_c   = 40'(pcb_r) - 40'(qcb_r) * 40'(DC);
    qfs     = qsb_r + 31'(rem_s >= 40'(DS));
    qfc     = qcb_r + 31'(rem_c >= 40'(DC));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      psa_r <= ps_full[60:30];
      pca_r <= pc_full[60:30];
      r2a_r <= r2_i;
      sda_r <= side_i;
      qsb_r <= qs_full[62:32];
      qcb_r <= qc_full[62:32];
      psb_r <= psa_r;
      pcb_r <= pca_r;
      r2b_r <= r2a_r;
      sdb_r <= sda_r;
      tsc_r <= QONE - qfs;
      tcc_r <= QONE - qfc;
      r2c_r <= r2b_r;
      sdc_r <= sdb_r;
    end
  end

  assign r2_o   = r2c_r;
  assign ts_o   = tsc_r;
  assign tc_o   = tcc_r;
  assign side_o = sdc_r;

endmodule

// File: rtl/e2d_sincos.sv
// Sine and cosine of one Q3.12 angle: range reduction, series chain, quadrant map
module e2d_sincos import e2d_pkg::*; #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [ANGLE_WIDTH-1:0] angle,
  output logic signed [31:0]            sin_o,
  output logic signed [31:0]            cos_o
);

  localparam int SHIFT = 34 - ANGLE_WIDTH;

  logic signed [34:0] a_in;
  logic signed [35:0] n_w, qh, r_w;
  logic [RANGE_STEPS-1:0] ge, lt;
  logic signed [3:0] q_nxt;
  logic signed [63:0] sq;

  logic signed [34:0] a0_r;
  logic signed [3:0]  q0_r;
  logic signed [31:0] r1_r;
  quad_t              quad1_r;
  logic [29:0]        r2_r;
  logic [33:0]        side2_r;

  logic [29:0] c_r2   [SERIES_TERMS+1];
  logic [30:0] c_ts   [SERIES_TERMS+1];
  logic [30:0] c_tc   [SERIES_TERMS+1];
  logic [33:0] c_side [SERIES_TERMS+1];

  logic signed [31:0] sra_r, cra_r, s_r, c_r, sr_w;
  quad_t              quada_r, quadc;

  assign a_in = 35'(angle) <<< SHIFT;
  assign n_w  = 36'(a_in) + 36'(QTR_PI);

  // q = floor(n / half pi) by comparing against the multiples
  always_comb begin
    for (int m = 1; m <= RANGE_STEPS; m++) begin
      ge[m-1] = (n_w >= 36'(longint'(m) * HALF_PI));
      lt[m-1] = (n_w < 36'(-longint'(m - 1) * HALF_PI));
    end
    q_nxt = 4'($countones(ge)) - 4'($countones(lt));
    qh    = 36'(q0_r) * 36'(HALF_PI);
    r_w   = 36'(a0_r) - qh;
    sq    = 64'(r1_r) * 64'(r1_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r    <= a_in;
      q0_r    <= q_nxt;
      r1_r    <= r_w[31:0];
      quad1_r <= quad_t'(q0_r[1:0]);
      r2_r    <= sq[59:30];
      side2_r <= {quad1_r, r1_r};
    end
  end

  assign c_r2[0]   = r2_r;
  assign c_ts[0]   = QONE;
  assign c_tc[0]   = QONE;
  assign c_side[0] = side2_r;

  for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_term
    e2d_trig_cell #(
      .K      (SERIES_TERMS - i),
      .SIDE_W (34)
    ) u_cell (
      .clk    (clk),
      .en     (en),
      .r2_i   (c_r2[i]),
      .ts_i   (c_ts[i]),
      .tc_i   (c_tc[i]),
      .side_i (c_side[i]),
      .r2_o   (c_r2[i+1]),
      .ts_o   (c_ts[i+1]),
      .tc_o   (c_tc[i+1]),
      .side_o (c_side[i+1])
    );
  end

  assign sr_w = qmul($signed(c_side[SERIES_TERMS][31:0]),
                     $signed({1'b0, c_ts[SERIES_TERMS]}));
  assign quadc = quad_t'(c_side[SERIES_TERMS][33:32]);

  always_ff @(posedge clk) begin
    if (en) begin
      sra_r   <= sr_w;
      cra_r   <= $signed({1'b0, c_tc[SERIES_TERMS]});
      quada_r <= quadc;
      case (quada_r)
        QUAD_0: begin
          s_r <= sra_r;
          c_r <= cra_r;
        end
        QUAD_90: begin
          s_r <= cra_r;
          c_r <= -sra_r;
        end
        QUAD_180: begin
          s_r <= -sra_r;
          c_r <= -cra_r;
        end
        default: begin
          s_r <= -cra_r;
          c_r <= sra_r;
        end
      endcase
    end
  end

  assign sin_o = s_r;
  assign cos_o = c_r;

endmodule

// File: rtl/e2d_sqrt_cell.sv
// One result bit of the integer square root, one register stage
module e2d_sqrt_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 99
) (
  input  logic              clk,
  input  logic              en,
  input  logic [63:0]       rem_i,
  input  logic [63:0]       root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [63:0]       rem_o,
  output logic [63:0]       root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [63:0] trial, rem_nxt, root_nxt;
  logic [63:0] rem_r, root_r;
  logic [SIDE_W-1:0] side_r;

  always_comb begin
    trial = root_i + BIT;
    if (rem_i >= trial) begin
      rem_nxt  = rem_i - trial;
      root_nxt = (root_i >> 1) + BIT;
    end else begin
      rem_nxt  = rem_i;
      root_nxt = root_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

// File: rtl/e2d_div_cell.sv
// One quotient bit of the three restoring divisions by the norm
module e2d_div_cell import e2d_pkg::*; #(
  parameter int J     = 0,
  parameter int REM_W = 47,
  parameter int QUO_W = 15
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2:0][REM_W-1:0] rem_i,
  input  logic [2:0][QUO_W-1:0] quo_i,
  input  logic [31:0]           norm_i,
  input  comp_flags_t           flags_i,
  output logic [2:0][REM_W-1:0] rem_o,
  output logic [2:0][QUO_W-1:0] quo_o,
  output logic [31:0]           norm_o,
  output comp_flags_t           flags_o
);

  logic [REM_W-1:0]            dv;
  logic [2:0][REM_W-1:0]       rem_nxt, rem_r;
  logic [2:0][QUO_W-1:0]       quo_nxt, quo_r;
  logic [31:0]                 norm_r;
  comp_flags_t                 flags_r;

  always_comb begin
    dv = REM_W'(norm_i) << J;
    for (int c = 0; c < 3; c++) begin
      if (rem_i[c] >= dv) begin
        rem_nxt[c] = rem_i[c] - dv;
        quo_nxt[c] = quo_i[c] | (QUO_W'(1) << J);
      end else begin
        rem_nxt[c] = rem_i[c];
        quo_nxt[c] = quo_i[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r   <= rem_nxt;
      quo_r   <= quo_nxt;
      norm_r  <= norm_i;
      flags_r <= flags_i;
    end
  end

  assign rem_o   = rem_r;
  assign quo_o   = quo_r;
  assign norm_o  = norm_r;
  assign flags_o = flags_r;

endmodule

// File: rtl/euler_to_direction_vector.sv
// Top level: three Euler angles in, normalized direction vector out
//
//  channel | dir | tdata fields (low bit up)                | tuser
//  in_     | in  | angle_about_x, angle_about_y, angle_about_z | -
//  out_    | out | dir_x, dir_y, dir_z                          | -
//
// One set of angles per cycle while the result buffer has room; fully pipelined in
// 65 + COMPONENT_WIDTH - 2 register stages (26 sine/cosine, 4 rotation and square,
// 32 root, one dividend, one per quotient bit, one output) plus the result buffer.
// rst_n clears only the valid bits and the two-entry result buffer.
// A stalled result sits in the buffer; the pipe keeps moving until both entries fill.
module euler_to_direction_vector import e2d_pkg::*; #(
  parameter int ANGLE_WIDTH     = 16,
  parameter int COMPONENT_WIDTH = 16,
  localparam int IN_W  = ((3 * ANGLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((3 * COMPONENT_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // angle_about_x, angle_about_y, angle_about_z
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // dir_x, dir_y, dir_z
);

  localparam int AW     = ANGLE_WIDTH;
  localparam int CW     = COMPONENT_WIDTH;
  localparam int CF     = CW - 2;
  localparam int REM_W  = CF + 33;
  localparam int QUO_W  = CF + 1;
  localparam int SIDE_W = 3 + 3 * 32;
  localparam int STAGES = SC_STAGES + 4 + ROOT_STEPS + 1 + QUO_W + 1;

  logic en;
  logic signed [31:0] sx, cx, sy, cy, sz, cz;

  e2d_sincos #(.ANGLE_WIDTH(AW)) u_sc_x (
    .clk(clk), .en(en), .angle($signed(in_tdata[AW-1:0])), .sin_o(sx), .cos_o(cx)
  );
  e2d_sincos #(.ANGLE_WIDTH(AW)) u_sc_y (
    .clk(clk), .en(en), .angle($signed(in_tdata[2*AW-1:AW])), .sin_o(sy), .cos_o(cy)
  );
  e2d_sincos #(.ANGLE_WIDTH(AW)) u_sc_z (
    .clk(clk), .en(en), .angle($signed(in_tdata[3*AW-1:2*AW])), .sin_o(sz), .cos_o(cz)
  );

  // rotation, then squares and sum
  logic signed [31:0] p1_r, p2_r, p3_r, p4_r, vz1_r, sx1_r;
  logic signed [32:0] vx2_r, vy2_r, vz2_r;
  logic signed [2:0][32:0] v2;
  logic [2:0][31:0] mag_w, mag1_r, mag2_r;
  logic [2:0][32:0] abs_w;
  logic [2:0][63:0] sq1_r;
  logic [2:0]       neg1_r, neg2_r;
  logic [63:0]      sum2_r;

  assign v2 = {vz2_r, vy2_r, vx2_r};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      abs_w[c] = v2[c][32] ? 33'(-v2[c]) : 33'(v2[c]);
      mag_w[c] = abs_w[c][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= qmul(cz, sy);
      p2_r  <= qmul(sz, sy);
      p3_r  <= qmul(sz, cx);
      p4_r  <= qmul(cz, cx);
      vz1_r <= qmul(cy, sx);
      sx1_r <= sx;
      vx2_r <= 33'(qmul(p1_r, sx1_r)) - 33'(p3_r);
      vy2_r <= 33'(qmul(p2_r, sx1_r)) + 33'(p4_r);
      vz2_r <= 33'(vz1_r);
      for (int c = 0; c < 3; c++) begin
        mag1_r[c] <= mag_w[c];
        sq1_r[c]  <= 64'(mag_w[c]) * 64'(mag_w[c]);
        neg1_r[c] <= v2[c][32];
      end
      sum2_r <= sq1_r[0] + sq1_r[1] + sq1_r[2];
      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
    end
  end

  // square root chain
  logic [63:0]       s_rem  [ROOT_STEPS+1];
  logic [63:0]       s_root [ROOT_STEPS+1];
  logic [SIDE_W-1:0] s_side [ROOT_STEPS+1];

  assign s_rem[0]  = sum2_r;
  assign s_root[0] = '0;
  assign s_side[0] = {neg2_r, mag2_r};

  for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
    e2d_sqrt_cell #(.STEP(i), .SIDE_W(SIDE_W)) u_cell (
      .clk(clk), .en(en),
      .rem_i(s_rem[i]), .root_i(s_root[i]), .side_i(s_side[i]),
      .rem_o(s_rem[i+1]), .root_o(s_root[i+1]), .side_o(s_side[i+1])
    );
  end

  // rounded dividend: (mag << CF) + norm / 2
  logic [31:0]            norm_w;
  logic [2:0][31:0]       mag_s;
  logic [2:0][REM_W-1:0]  d_rem  [QUO_W+1];
  logic [2:0][QUO_W-1:0]  d_quo  [QUO_W+1];
  logic [31:0]            d_norm [QUO_W+1];
  comp_flags_t            d_flg  [QUO_W+1];
  logic [2:0][REM_W-1:0]  rem0_r;
  logic [31:0]            norm0_r;
  comp_flags_t            flg0_r;

  assign norm_w = s_root[ROOT_STEPS][31:0];
  assign mag_s  = s_side[ROOT_STEPS][95:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        rem0_r[c] <= (REM_W'(mag_s[c]) << CF) + REM_W'(norm_w >> 1);
      end
      norm0_r    <= norm_w;
      flg0_r.nz  <= (norm_w != 32'd0);
      flg0_r.neg <= s_side[ROOT_STEPS][98:96];
    end
  end

  assign d_rem[0]  = rem0_r;
  assign d_quo[0]  = '0;
  assign d_norm[0] = norm0_r;
  assign d_flg[0]  = flg0_r;

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    e2d_div_cell #(.J(CF - i), .REM_W(REM_W), .QUO_W(QUO_W)) u_cell (
      .clk(clk), .en(en),
      .rem_i(d_rem[i]), .quo_i(d_quo[i]), .norm_i(d_norm[i]), .flags_i(d_flg[i]),
      .rem_o(d_rem[i+1]), .quo_o(d_quo[i+1]), .norm_o(d_norm[i+1]),
      .flags_o(d_flg[i+1])
    );
  end

  // sign and pack
  logic [OUT_W-1:0] out_nxt, out_r;
  comp_flags_t      flg_f;
  logic [CW-1:0]    comp;

  assign flg_f = d_flg[QUO_W];

  always_comb begin
    out_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      comp = CW'(d_quo[QUO_W][c]);
      if (!flg_f.nz) begin
        comp = '0;
      end else if (flg_f.neg[c]) begin
        comp = -comp;
      end
      out_nxt[c*CW +: CW] = comp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  e2d_flow #(.STAGES(STAGES), .DATA_W(OUT_W)) u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .en        (en),
    .last_data (out_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// File: rtl/e2d_checker.sv
// Port-level checks of the direction vector block, bound to the top level
`include "euler_to_direction_vector_assert.svh"

module e2d_checker #(
  parameter int ANGLE_WIDTH     = 16,
  parameter int COMPONENT_WIDTH = 16,
  localparam int OUT_W = ((3 * COMPONENT_WIDTH + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam int CW  = COMPONENT_WIDTH;
  localparam int LIM = 1 << (CW - 2);
  localparam int AWC = ANGLE_WIDTH;

  logic signed [CW-1:0] cx, cy, cz;
  logic                 in_range;

  assign cx = $signed(out_tdata[CW-1:0]);
  assign cy = $signed(out_tdata[2*CW-1:CW]);
  assign cz = $signed(out_tdata[3*CW-1:2*CW]);
  assign in_range = (AWC > 0) && (cx <= LIM) && (cx >= -LIM) && (cy <= LIM)
                    && (cy >= -LIM) && (cz <= LIM) && (cz >= -LIM);

  `E2D_ASSERT_ALWAYS(a_reset_clears, !rst_n, !out_tvalid && in_tready, "reset left state")
  `E2D_ASSERT_NOW(a_idle_ready, !out_tvalid, in_tready, "input blocked with empty buffer")
  `E2D_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped")
  `E2D_ASSERT_NOW(a_unit_range, out_tvalid, in_range, "component beyond unit magnitude")

endmodule

bind euler_to_direction_vector e2d_checker #(
  .ANGLE_WIDTH     (ANGLE_WIDTH),
  .COMPONENT_WIDTH (COMPONENT_WIDTH)
) u_e2d_checker (.*);
